>>> rtl/core/lfga_pkg.sv
// ----------------------------------------------------------------------------
// lfga_pkg
// Shared widths, action codes and controller/datapath interface types for the
// lowest-free gate allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfga_pkg;

  localparam int unsigned ActW   = 2;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GateW  = 5;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 5;

  localparam logic [CfgW-1:0] CfgReset = 5'd16;

  localparam logic KindAlloc  = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [ActW-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_REPORT  = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the request operands
    logic clear;      // free all gates, zero all counts
    logic search;     // compare, encode, read count of the chosen gate
    logic cnt_rd;     // read count at the report pointer
    logic alloc_wr;   // write back allocation, load allocation result
    logic rpt_start;  // zero the report pointer and running sum
    logic rpt_out;    // add count to sum, load report result, advance pointer
  } lfga_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic idx_last;   // report pointer is on the last gate in use
  } lfga_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/lfga_datapath.sv
// ----------------------------------------------------------------------------
// lfga_datapath
// Gate tables, free-gate search, count memory, running sum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_datapath #(
  parameter int unsigned GATES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfga_pkg::lfga_cmd_t               cmd_i,
  output lfga_pkg::lfga_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [lfga_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic [lfga_pkg::TimeW-1:0]        arrival_time_i,
  input  logic [lfga_pkg::TimeW-1:0]        departure_time_i,
  output logic                              kind_o,
  output logic [lfga_pkg::GateW-1:0]        gate_o,
  output logic [lfga_pkg::CountW-1:0]       prefix_count_o,
  output logic                              last_o
);

  localparam int unsigned IdxW = (GATES > 1) ? $clog2(GATES) : 1;

  function automatic logic [lfga_pkg::CountW-1:0] sat_add(
    input logic [lfga_pkg::CountW-1:0] a,
    input logic [lfga_pkg::CountW-1:0] b
  );
    logic [lfga_pkg::CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[lfga_pkg::CountW] ? '1 : s[lfga_pkg::CountW-1:0];
  endfunction

  logic [lfga_pkg::CfgW-1:0]   cfg_q;
  logic [lfga_pkg::TimeW-1:0]  arr_q, dep_q;
  logic [lfga_pkg::TimeW-1:0]  busy_q [GATES];
  logic [lfga_pkg::CountW-1:0] cnt_mem [GATES];
  logic [GATES-1:0]            cnt_vld_q;
  logic [lfga_pkg::CountW-1:0] rd_q;
  logic                        rd_vld_q;
  logic                        hit_q;
  logic [IdxW-1:0]             idx_q;
  logic [IdxW-1:0]             ptr_q;
  logic [lfga_pkg::CountW-1:0] sum_q;

  logic                        out_kind_q;
  logic [lfga_pkg::GateW-1:0]  out_gate_q;
  logic [lfga_pkg::CountW-1:0] out_count_q;
  logic                        out_last_q;

  logic [IdxW-1:0]             last_idx;
  logic [GATES-1:0]            free;
  logic                        enc_hit;
  logic [IdxW-1:0]             enc_idx;
  logic [IdxW-1:0]             rd_addr;
  logic [lfga_pkg::CountW-1:0] rd_eff;
  logic [lfga_pkg::CountW-1:0] cnt_inc;
  logic [lfga_pkg::CountW-1:0] sum_nxt;
  logic                        ptr_last;

  // Highest gate index in use: zero counts as one, clamp to the table size
  always_comb begin
    if (cfg_q == '0) begin
      last_idx = '0;
    end else if (32'(cfg_q) > GATES) begin
      last_idx = IdxW'(GATES - 1);
    end else begin
      last_idx = IdxW'(32'(cfg_q) - 32'd1);
    end
  end

  // Free test on every gate in parallel, then pick the lowest
  always_comb begin
    for (int i = 0; i < GATES; i++) begin
      free[i] = (busy_q[i] <= arr_q) && (i <= int'(last_idx));
    end
    enc_hit = |free;
    enc_idx = '0;
    for (int i = GATES - 1; i >= 0; i--) begin
      if (free[i]) enc_idx = IdxW'(i);
    end
  end

  assign rd_addr  = cmd_i.search ? enc_idx : ptr_q;
  assign rd_eff   = rd_vld_q ? rd_q : '0;
  assign cnt_inc  = sat_add(rd_eff, lfga_pkg::CountW'(1));
  assign sum_nxt  = sat_add(sum_q, rd_eff);
  assign ptr_last = (ptr_q == last_idx);

  assign sts_o.idx_last = ptr_last;

  // Count memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_wr && hit_q) cnt_mem[idx_q] <= cnt_inc;
    if (cmd_i.search || cmd_i.cnt_rd) rd_q <= cnt_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= lfga_pkg::CfgReset;
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      idx_q     <= '0;
      ptr_q     <= '0;
      sum_q     <= '0;
      for (int i = 0; i < GATES; i++) busy_q[i] <= '0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (cmd_i.clear) begin
        cnt_vld_q <= '0;
        for (int i = 0; i < GATES; i++) busy_q[i] <= '0;
      end
      if (cmd_i.search) begin
        hit_q <= enc_hit;
        idx_q <= enc_idx;
      end
      if (cmd_i.search || cmd_i.cnt_rd) rd_vld_q <= cnt_vld_q[rd_addr];
      if (cmd_i.alloc_wr && hit_q) begin
        busy_q[idx_q]    <= dep_q;
        cnt_vld_q[idx_q] <= 1'b1;
      end
      if (cmd_i.rpt_start) begin
        ptr_q <= '0;
        sum_q <= '0;
      end else if (cmd_i.rpt_out) begin
        ptr_q <= ptr_q + IdxW'(1);
        sum_q <= sum_nxt;
      end
    end
  end

  // Operands and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      arr_q <= arrival_time_i;
      dep_q <= departure_time_i;
    end
    if (cmd_i.alloc_wr) begin
      out_kind_q  <= lfga_pkg::KindAlloc;
      out_gate_q  <= hit_q ? lfga_pkg::GateW'(32'(idx_q) + 32'd1) : '0;
      out_count_q <= '0;
      out_last_q  <= 1'b1;
    end else if (cmd_i.rpt_out) begin
      out_kind_q  <= lfga_pkg::KindReport;
      out_gate_q  <= lfga_pkg::GateW'(32'(ptr_q) + 32'd1);
      out_count_q <= sum_nxt;
      out_last_q  <= ptr_last;
    end
  end

  assign kind_o         = out_kind_q;
  assign gate_o         = out_gate_q;
  assign prefix_count_o = out_count_q;
  assign last_o         = out_last_q;

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> cnt_vld_q == '0)
    else $error("count table not emptied by clear");

  a_alloc_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr && hit_q |=> cnt_vld_q[idx_q])
    else $error("allocated gate count not marked written");

  a_report_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rpt_out && ptr_last |=> out_last_q && (out_kind_q == lfga_pkg::KindReport))
    else $error("last report entry not flagged");

endmodule

`default_nettype wire

>>> rtl/core/lfga_ctrl.sv
// ----------------------------------------------------------------------------
// lfga_ctrl
// Sequencer for request, report and clear actions; owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lfga_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [lfga_pkg::ActW-1:0]   action_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lfga_pkg::lfga_cmd_t         cmd_o,
  input  lfga_pkg::lfga_sts_t         sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ALLOC,
    S_RPT_RD,
    S_RPT_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   slot_free;
  logic   out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_load    = cmd_o.alloc_wr || cmd_o.rpt_out;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture   = in_acc;
        cmd_o.clear     = in_acc && (action_i == lfga_pkg::ACT_CLEAR);
        cmd_o.rpt_start = in_acc && (action_i == lfga_pkg::ACT_REPORT);
      end
      S_SEARCH:  cmd_o.search   = 1'b1;
      S_ALLOC:   cmd_o.alloc_wr = slot_free;
      S_RPT_RD:  cmd_o.cnt_rd   = 1'b1;
      S_RPT_OUT: cmd_o.rpt_out  = slot_free;
      default:   cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (action_i)
              lfga_pkg::ACT_REQUEST: state_q <= S_SEARCH;
              lfga_pkg::ACT_REPORT:  state_q <= S_RPT_RD;
              default:               state_q <= S_IDLE;
            endcase
          end
        end
        S_SEARCH: state_q <= S_ALLOC;
        S_ALLOC: begin
          if (slot_free) state_q <= S_IDLE;
        end
        S_RPT_RD: state_q <= S_RPT_OUT;
        S_RPT_OUT: begin
          if (slot_free) state_q <= sts_i.idx_last ? S_IDLE : S_RPT_RD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> slot_free)
    else $error("result loaded over an untaken result");

  a_request_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == lfga_pkg::ACT_REQUEST) |=> state_q == S_SEARCH)
    else $error("accepted request did not start a search");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_load))
    else $error("result valid raised without a load");

endmodule

`default_nettype wire

>>> rtl/core/lowest_free_gate_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_gate_allocator
// Assigns each request to the lowest-numbered free gate and reports running
// per-gate allocation totals.
// ----------------------------------------------------------------------------
// Request: result registered in the write-back state, after the search;
//   next request accepted once the sequencer has passed its capture,
//   search and write-back states; write-back waits for a free result slot.
// Report: count read, then sum, for each of the N in-use gates.
// Clear: done at acceptance, next item taken the following cycle.
// Reset: all gates free, all counts zero, gates_in_use = 16.
`default_nettype none

module lowest_free_gate_allocator #(
  parameter int unsigned GATES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lfga_pkg::ActW-1:0]     action_i,
  input  logic [lfga_pkg::TimeW-1:0]    arrival_time_i,
  input  logic [lfga_pkg::TimeW-1:0]    departure_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [lfga_pkg::GateW-1:0]    gate_o,
  output logic [lfga_pkg::CountW-1:0]   prefix_count_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [lfga_pkg::CfgW-1:0]     cfg_wdata_i
);

  lfga_pkg::lfga_cmd_t cmd;
  lfga_pkg::lfga_sts_t sts;

  lfga_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  lfga_datapath #(
    .GATES (GATES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .arrival_time_i   (arrival_time_i),
    .departure_time_i (departure_time_i),
    .kind_o           (kind_o),
    .gate_o           (gate_o),
    .prefix_count_o   (prefix_count_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lowest-free gate allocator. It drives requests,
// reports, clears and undefined actions under random idling on both sides. It
// also predicts every allocation and prefix-count entry from its own copy of
// the gate tables, and compares each result field by field.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned Gates        = 16;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ItemTarget   = 360;

  localparam logic [lfga_pkg::ActW-1:0]   ActUnknown = 2'd3;
  localparam logic [lfga_pkg::TimeW-1:0]  TimeMax    = '1;
  localparam logic [lfga_pkg::CountW-1:0] CountMax   = '1;

  typedef struct packed {
    logic                        kind;
    logic [lfga_pkg::GateW-1:0]  gate;
    logic [lfga_pkg::CountW-1:0] prefix_count;
    logic                        last;
  } gate_result_t;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic [lfga_pkg::ActW-1:0]     action_i         = '0;
  logic [lfga_pkg::TimeW-1:0]    arrival_time_i   = '0;
  logic [lfga_pkg::TimeW-1:0]    departure_time_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic                          kind_o;
  logic [lfga_pkg::GateW-1:0]    gate_o;
  logic [lfga_pkg::CountW-1:0]   prefix_count_o;
  logic                          last_o;
  logic                          cfg_we_i         = 1'b0;
  logic [lfga_pkg::CfgW-1:0]     cfg_wdata_i      = '0;

  // Own copy of the gate tables and the in-use register
  logic [lfga_pkg::TimeW-1:0]    free_at     [Gates];
  logic [lfga_pkg::CountW-1:0]   alloc_total [Gates];
  logic [lfga_pkg::CfgW-1:0]     gates_cfg;
  gate_result_t                  pending_results [$];
  gate_result_t                  oldest;

  logic [lfga_pkg::TimeW-1:0]    clock_cursor;
  bit                            no_stall = 1'b0;
  int unsigned                   errors = 0;
  int unsigned                   items_sent = 0;
  int unsigned                   allocs_seen = 0;
  int unsigned                   refusals_seen = 0;
  int unsigned                   report_entries_seen = 0;
  int unsigned                   quiet_cycles = 0;

  lowest_free_gate_allocator #(
    .GATES(Gates)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .arrival_time_i  (arrival_time_i),
    .departure_time_i(departure_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .gate_o          (gate_o),
    .prefix_count_o  (prefix_count_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [lfga_pkg::CountW-1:0] sat_add(logic [lfga_pkg::CountW-1:0] a,
                                                          logic [lfga_pkg::CountW-1:0] b);
    logic [lfga_pkg::CountW:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[lfga_pkg::CountW] ? CountMax : total[lfga_pkg::CountW-1:0];
  endfunction

  function automatic void predict_gate_results(logic [lfga_pkg::ActW-1:0] action,
                                               logic [lfga_pkg::TimeW-1:0] arrival,
                                               logic [lfga_pkg::TimeW-1:0] departure);
    int unsigned                 n;
    bit                          placed;
    logic [lfga_pkg::CountW-1:0] running;
    n = (gates_cfg == 0) ? 1 : ((gates_cfg > Gates) ? Gates : int'(gates_cfg));
    placed  = 1'b0;
    running = '0;
    case (action)
      lfga_pkg::ACT_REQUEST: begin
        for (int i = 0; i < n; i++) begin
          if (!placed && free_at[i] <= arrival) begin
            free_at[i]     = departure;
            alloc_total[i] = sat_add(alloc_total[i], 1);
            placed         = 1'b1;
            pending_results.push_back(gate_result_t'{lfga_pkg::KindAlloc,
                                                     lfga_pkg::GateW'(i + 1), '0, 1'b1});
          end
        end
        if (!placed) begin
          pending_results.push_back(gate_result_t'{lfga_pkg::KindAlloc, '0, '0, 1'b1});
        end
      end
      lfga_pkg::ACT_REPORT: begin
        for (int i = 0; i < n; i++) begin
          running = sat_add(running, alloc_total[i]);
          pending_results.push_back(gate_result_t'{lfga_pkg::KindReport,
                                                   lfga_pkg::GateW'(i + 1), running,
                                                   (i == n - 1)});
        end
      end
      lfga_pkg::ACT_CLEAR: begin
        for (int i = 0; i < Gates; i++) begin
          free_at[i]     = '0;
          alloc_total[i] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [lfga_pkg::ActW-1:0] action,
                           input logic [lfga_pkg::TimeW-1:0] arrival,
                           input logic [lfga_pkg::TimeW-1:0] departure);
    while (!no_stall && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= action;
    arrival_time_i   <= arrival;
    departure_time_i <= departure;
    do @(posedge clk_i); while (!in_ready_o);
    predict_gate_results(action, arrival, departure);
    if (action != ActUnknown) items_sent++;
  endtask

  // Hold off until every result is in and the block has settled
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_gates_in_use(input logic [lfga_pkg::CfgW-1:0] value);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gates_cfg    = value;
  endtask

  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 74) begin
      // well-formed request: arrivals never move back, departures follow them
      clock_cursor += $urandom_range(0, 3);
      send_item(lfga_pkg::ACT_REQUEST, clock_cursor,
                clock_cursor + $urandom_range(1, 3 * gates_cfg + 4));
    end else if (pick < 82) begin
      send_item(lfga_pkg::ACT_REPORT, $urandom, $urandom);
    end else if (pick < 86) begin
      send_item(lfga_pkg::ACT_CLEAR, $urandom, $urandom);
    end else if (pick < 88) begin
      send_item(ActUnknown, $urandom, $urandom);
    end else if (pick < 92) begin
      send_item(lfga_pkg::ACT_REQUEST, $urandom, $urandom);
    end else begin
      // arrival at or behind the stream, departure possibly not after it
      send_item(lfga_pkg::ACT_REQUEST, clock_cursor - $urandom_range(0, 8),
                clock_cursor - $urandom_range(0, 8));
    end
  endtask

  task automatic test_default_gates();
    send_item(lfga_pkg::ACT_REQUEST, '0, TimeMax);
    send_item(lfga_pkg::ACT_REQUEST, '0, 32'd10);
    send_item(lfga_pkg::ACT_REPORT, TimeMax, '0);
  endtask

  task automatic test_single_gate();
    write_gates_in_use(5'd0);
    send_item(lfga_pkg::ACT_CLEAR, '0, '0);
    send_item(lfga_pkg::ACT_REQUEST, '0, TimeMax);
    send_item(lfga_pkg::ACT_REQUEST, TimeMax, 32'd1);
    send_item(lfga_pkg::ACT_REQUEST, '0, 32'd5);
    send_item(lfga_pkg::ACT_REQUEST, 32'd1, '0);
    send_item(lfga_pkg::ACT_REQUEST, '0, 32'd3);
    send_item(ActUnknown, TimeMax, TimeMax);
    send_item(lfga_pkg::ACT_REPORT, '0, '0);
  endtask

  task automatic test_gate_range();
    write_gates_in_use(5'd16);
    send_item(lfga_pkg::ACT_CLEAR, '0, '0);
    repeat (3) send_item(lfga_pkg::ACT_REQUEST, 32'd100, 32'd200);
    write_gates_in_use(5'd1);
    send_item(lfga_pkg::ACT_REQUEST, 32'd150, 32'd300);
    send_item(lfga_pkg::ACT_REQUEST, 32'd200, 32'd300);
    write_gates_in_use(5'd31);
    send_item(lfga_pkg::ACT_REPORT, '0, '0);
    send_item(lfga_pkg::ACT_REQUEST, 32'd150, 32'd400);
    write_gates_in_use(5'd17);
    send_item(lfga_pkg::ACT_REQUEST, 32'd150, 32'd400);
  endtask

  task automatic test_steady_stream();
    int unsigned target;
    write_gates_in_use(5'd16);
    target   = items_sent + 100;
    no_stall = 1'b1;
    while (items_sent < target) send_random_item();
    no_stall = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [lfga_pkg::CfgW-1:0] settings [6];
    int unsigned               target;
    settings = '{5'd1, 5'd3, 5'd8, 5'd31, 5'd0, 5'd16};
    foreach (settings[k]) begin
      write_gates_in_use(settings[k]);
      target = items_sent + 30;
      while (items_sent < target) send_random_item();
    end
    while (items_sent < ItemTarget) begin
      write_gates_in_use(lfga_pkg::CfgW'($urandom_range(0, 31)));
      target = items_sent + 30;
      if (target > ItemTarget) target = ItemTarget;
      while (items_sent < target) send_random_item();
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= no_stall || ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got kind %0d gate %0d count %0d last %0d",
                 $time, kind_o, gate_o, prefix_count_o, last_o);
      end else begin
        oldest = pending_results.pop_front();
        if (kind_o !== oldest.kind) begin
          errors++;
          $display("%0t: kind mismatch: expected %0d, got %0d", $time, oldest.kind, kind_o);
        end
        if (gate_o !== oldest.gate) begin
          errors++;
          $display("%0t: gate mismatch: expected %0d, got %0d", $time, oldest.gate, gate_o);
        end
        if (prefix_count_o !== oldest.prefix_count) begin
          errors++;
          $display("%0t: prefix_count mismatch: expected %0d, got %0d", $time,
                   oldest.prefix_count, prefix_count_o);
        end
        if (last_o !== oldest.last) begin
          errors++;
          $display("%0t: last mismatch: expected %0d, got %0d", $time, oldest.last, last_o);
        end
        if (oldest.kind == lfga_pkg::KindReport) report_entries_seen++;
        else if (oldest.gate == 0) refusals_seen++;
        else allocs_seen++;
      end
    end
  end

  // Drop the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no request or result accepted for %0d cycles", $time, StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    gates_cfg    = lfga_pkg::CfgReset;
    clock_cursor = '0;
    predict_gate_results(lfga_pkg::ACT_CLEAR, '0, '0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_gates();
    test_single_gate();
    test_gate_range();
    test_steady_stream();
    test_random_phases();

    wait_for_drain();
    $display("Sent %0d requests, reports and clears over gate settings 0 to 31.", items_sent);
    $display("Checked %0d allocations, %0d refusals and %0d report entries.",
             allocs_seen, refusals_seen, report_entries_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
